FILE: rtl/fps_camera_pose_and_view_assert.svh
// Assertion macros shared by the checker of the camera pose block.
// Depends on nothing; the including scope supplies clk and rst.
`ifndef FPS_CAMERA_POSE_AND_VIEW_ASSERT_SVH
`define FPS_CAMERA_POSE_AND_VIEW_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FPSCAM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("camera pose check failed");

// Consequent must hold in the cycle after the antecedent.
`define FPSCAM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("camera pose check failed");

`endif

FILE: rtl/fpscam_pkg.sv
// Shared types, constants and tables of the camera pose block.
// Used by the controller, the datapath and the top level.
package fpscam_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ITER_W = $clog2(CORDIC_STEPS);
  localparam int CW = 34;
  localparam int OP_W = 5;
  localparam int NUM_OPS = 24;
  localparam logic [OP_W-1:0] OP_LAST = OP_W'(NUM_OPS - 1);
  // In load mode the move steps are skipped: after the last pair product
  // the sequence jumps to the bubble in front of the translation.
  localparam logic [OP_W-1:0] OP_SKIP_FROM = OP_W'(3);
  localparam logic [OP_W-1:0] OP_SKIP_TO = OP_W'(12);

  localparam logic signed [CW-1:0] ANG_PI = 34'sd843314857;
  localparam logic signed [CW-1:0] ANG_HALF_PI = 34'sd421657428;
  localparam logic signed [CW-1:0] ANG_TWO_PI = 34'sd1686629713;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CINIT, ST_CRUN, ST_CSTORE, ST_OPS, ST_DRAIN, ST_OUT
  } state_t;

  typedef enum logic [1:0] {OK_NOP, OK_PROD, OK_MAC, OK_WB} op_kind_t;

  typedef enum logic [3:0] {
    SRC_SY, SRC_CY, SRC_SP, SRC_CP, SRC_RX, SRC_RZ,
    SRC_P0, SRC_P1, SRC_P2, SRC_P3, SRC_PX, SRC_PY, SRC_PZ, SRC_DX, SRC_DZ
  } src_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_P0, DST_P1, DST_P2, DST_P3,
    DST_PX, DST_PY, DST_PZ, DST_TX, DST_TY, DST_TZ
  } dst_t;

  typedef struct packed {
    op_kind_t kind;
    src_t     a;
    src_t     b;
    logic     sh;
    logic     neg;
    logic     clr;
    dst_t     dst;
  } op_t;

  typedef struct packed {
    logic              load_in;
    logic              cordic_init;
    logic              cordic_step;
    logic              cordic_store;
    logic              cordic_sel;
    logic [ITER_W-1:0] iter;
    logic              op_valid;
    logic [OP_W-1:0]   op_idx;
  } ctl_cmd_t;

  typedef struct packed {
    logic mode;
  } dp_status_t;

  function automatic logic signed [CW-1:0] atan_q28(input logic [4:0] idx);
    logic signed [CW-1:0] v;
    case (idx)
      5'd0:  v = 34'sd210828714;
      5'd1:  v = 34'sd124459457;
      5'd2:  v = 34'sd65760959;
      5'd3:  v = 34'sd33381290;
      5'd4:  v = 34'sd16755422;
      5'd5:  v = 34'sd8385879;
      5'd6:  v = 34'sd4193963;
      5'd7:  v = 34'sd2097109;
      5'd8:  v = 34'sd1048571;
      5'd9:  v = 34'sd524287;
      5'd10: v = 34'sd262144;
      5'd11: v = 34'sd131072;
      5'd12: v = 34'sd65536;
      5'd13: v = 34'sd32768;
      5'd14: v = 34'sd16384;
      5'd15: v = 34'sd8192;
      5'd16: v = 34'sd4096;
      5'd17: v = 34'sd2048;
      5'd18: v = 34'sd1024;
      5'd19: v = 34'sd512;
      5'd20: v = 34'sd256;
      5'd21: v = 34'sd128;
      5'd22: v = 34'sd64;
      5'd23: v = 34'sd32;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic op_t mk(input op_kind_t k, input src_t a, input src_t b,
                             input logic sh, input logic neg, input logic clr,
                             input dst_t d);
    op_t o;
    o.kind = k; o.a = a; o.b = b; o.sh = sh; o.neg = neg; o.clr = clr; o.dst = d;
    return o;
  endfunction

  // Translation sums are accumulated negated so that write-back only rounds.
  function automatic op_t op_rom(input logic [OP_W-1:0] idx);
    op_t o;
    case (idx)
      5'd0:  o = mk(OK_PROD, SRC_SY, SRC_SP, 1'b0, 1'b0, 1'b0, DST_P0);
      5'd1:  o = mk(OK_PROD, SRC_SY, SRC_CP, 1'b0, 1'b0, 1'b0, DST_P1);
      5'd2:  o = mk(OK_PROD, SRC_CY, SRC_SP, 1'b0, 1'b0, 1'b0, DST_P2);
      5'd3:  o = mk(OK_PROD, SRC_CY, SRC_CP, 1'b0, 1'b0, 1'b0, DST_P3);
      5'd4:  o = mk(OK_MAC,  SRC_RX, SRC_DX, 1'b1, 1'b0, 1'b1, DST_NONE);
      5'd5:  o = mk(OK_MAC,  SRC_P1, SRC_DZ, 1'b0, 1'b0, 1'b0, DST_NONE);
      5'd6:  o = mk(OK_WB,   SRC_SY, SRC_SY, 1'b0, 1'b0, 1'b0, DST_PX);
      5'd7:  o = mk(OK_MAC,  SRC_SP, SRC_DZ, 1'b1, 1'b0, 1'b1, DST_NONE);
      5'd8:  o = mk(OK_WB,   SRC_SY, SRC_SY, 1'b0, 1'b0, 1'b0, DST_PY);
      5'd9:  o = mk(OK_MAC,  SRC_RZ, SRC_DX, 1'b1, 1'b0, 1'b1, DST_NONE);
      5'd10: o = mk(OK_MAC,  SRC_P3, SRC_DZ, 1'b0, 1'b0, 1'b0, DST_NONE);
      5'd11: o = mk(OK_WB,   SRC_SY, SRC_SY, 1'b0, 1'b0, 1'b0, DST_PZ);
      5'd12: o = mk(OK_NOP,  SRC_SY, SRC_SY, 1'b0, 1'b0, 1'b0, DST_NONE);
      5'd13: o = mk(OK_MAC,  SRC_PX, SRC_CY, 1'b1, 1'b1, 1'b1, DST_NONE);
      5'd14: o = mk(OK_MAC,  SRC_PZ, SRC_SY, 1'b1, 1'b0, 1'b0, DST_NONE);
      5'd15: o = mk(OK_WB,   SRC_SY, SRC_SY, 1'b0, 1'b0, 1'b0, DST_TX);
      5'd16: o = mk(OK_MAC,  SRC_PX, SRC_P0, 1'b0, 1'b1, 1'b1, DST_NONE);
      5'd17: o = mk(OK_MAC,  SRC_PY, SRC_CP, 1'b1, 1'b1, 1'b0, DST_NONE);
      5'd18: o = mk(OK_MAC,  SRC_PZ, SRC_P2, 1'b0, 1'b1, 1'b0, DST_NONE);
      5'd19: o = mk(OK_WB,   SRC_SY, SRC_SY, 1'b0, 1'b0, 1'b0, DST_TY);
      5'd20: o = mk(OK_MAC,  SRC_PX, SRC_P1, 1'b0, 1'b1, 1'b1, DST_NONE);
      5'd21: o = mk(OK_MAC,  SRC_PY, SRC_SP, 1'b1, 1'b0, 1'b0, DST_NONE);
      5'd22: o = mk(OK_MAC,  SRC_PZ, SRC_P3, 1'b0, 1'b1, 1'b0, DST_NONE);
      5'd23: o = mk(OK_WB,   SRC_SY, SRC_SY, 1'b0, 1'b0, 1'b0, DST_TZ);
      default: o = mk(OK_NOP, SRC_SY, SRC_SY, 1'b0, 1'b0, 1'b0, DST_NONE);
    endcase
    return o;
  endfunction

endpackage

FILE: rtl/fpscam_ctrl.sv
// Sequencer of the camera pose block: runs the CORDIC twice, then the
// multiply-accumulate program, then holds the result. Uses fpscam_pkg.
module fpscam_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  fpscam_pkg::dp_status_t status,
  output fpscam_pkg::ctl_cmd_t   cmd
);
  import fpscam_pkg::*;

  state_t            state, state_next;
  logic [ITER_W-1:0] iter, iter_next;
  logic              sel, sel_next;
  logic [OP_W-1:0]   op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      iter  <= '0;
      sel   <= 1'b0;
      op    <= '0;
    end else begin
      state <= state_next;
      iter  <= iter_next;
      sel   <= sel_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    iter_next  = iter;
    sel_next   = sel;
    op_next    = op;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    cmd.cordic_sel = sel;
    cmd.iter       = iter;
    cmd.op_idx     = op;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          sel_next    = 1'b0;
          state_next  = ST_CINIT;
        end
      end
      ST_CINIT: begin
        cmd.cordic_init = 1'b1;
        iter_next       = '0;
        state_next      = ST_CRUN;
      end
      ST_CRUN: begin
        cmd.cordic_step = 1'b1;
        iter_next       = iter + 1'b1;
        if (iter == ITER_W'(CORDIC_STEPS - 1)) begin
          state_next = ST_CSTORE;
        end
      end
      ST_CSTORE: begin
        cmd.cordic_store = 1'b1;
        if (!sel) begin
          sel_next   = 1'b1;
          state_next = ST_CINIT;
        end else begin
          op_next    = '0;
          state_next = ST_OPS;
        end
      end
      ST_OPS: begin
        cmd.op_valid = 1'b1;
        if (op == OP_LAST) begin
          state_next = ST_DRAIN;
        end else if (op == OP_SKIP_FROM && status.mode) begin
          op_next = OP_SKIP_TO;
        end else begin
          op_next = op + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/fpscam_datapath.sv
// Datapath of the camera pose block: input registers, shared CORDIC,
// one 33x33 multiplier with accumulator, pose and result registers.
// Uses fpscam_pkg for the operation table and command types.
module fpscam_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  fpscam_pkg::ctl_cmd_t   cmd,
  output fpscam_pkg::dp_status_t status,
  input  logic                   mode,
  input  logic signed [15:0]     yaw_angle,
  input  logic signed [15:0]     pitch_angle,
  input  logic signed [31:0]     delta_x,
  input  logic signed [31:0]     delta_y,
  input  logic signed [31:0]     delta_z,
  output logic signed [15:0]     rot_00,
  output logic signed [15:0]     rot_01,
  output logic signed [15:0]     rot_02,
  output logic signed [15:0]     rot_10,
  output logic signed [15:0]     rot_11,
  output logic signed [15:0]     rot_12,
  output logic signed [15:0]     rot_20,
  output logic signed [15:0]     rot_21,
  output logic signed [15:0]     rot_22,
  output logic signed [31:0]     trans_x,
  output logic signed [31:0]     trans_y,
  output logic signed [31:0]     trans_z
);
  import fpscam_pkg::*;

  logic               mode_q;
  logic signed [15:0] yaw_q, pitch_q;
  logic signed [31:0] dx_q, dy_q, dz_q;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic signed [31:0] tx, ty, tz;
  logic signed [15:0] sy, cy, sp, cp;
  logic signed [31:0] p0, p1, p2, p3;

  logic signed [CW-1:0] cx, cyv, cz;
  logic                 cneg;
  logic signed [65:0]   prod;
  logic signed [63:0]   acc;
  op_t                  op_q;

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    logic signed [31:0] r;
    if (v > 38'sd2147483647) r = 32'sh7fffffff;
    else if (v < -38'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [15:0] rnd14(input logic signed [31:0] v);
    logic signed [31:0] t;
    t = v + 32'sd8192;
    return t[29:14];
  endfunction

  function automatic logic signed [32:0] ext16(input logic signed [15:0] v);
    return {{17{v[15]}}, v};
  endfunction

  function automatic logic signed [32:0] ext32(input logic signed [31:0] v);
    return {v[31], v};
  endfunction

  assign status.mode = mode_q;

  // Input registers and angle state.
  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_q   <= '0;
      pitch_q <= '0;
    end else if (cmd.load_in) begin
      yaw_q   <= yaw_angle;
      pitch_q <= pitch_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_q <= mode;
      dx_q   <= delta_x;
      dy_q   <= delta_y;
      dz_q   <= delta_z;
    end
  end

  // CORDIC: range reduction and fold at init, one rotation per step.
  logic signed [CW-1:0] z0, z1, z2, zf;
  logic                 fold;
  logic signed [CW-1:0] xs, ys, atn, xo;
  logic signed [CW-1:0] xr;
  logic signed [17:0]   qv;
  logic signed [15:0]   qc, qs;
  logic signed [17:0]   qy;

  always_comb begin
    z0 = {{2{(cmd.cordic_sel ? pitch_q[15] : yaw_q[15])}},
          (cmd.cordic_sel ? pitch_q : yaw_q), 16'b0};
    z1 = (z0 > ANG_PI) ? z0 - ANG_TWO_PI : z0;
    z2 = (z1 < -ANG_PI) ? z1 + ANG_TWO_PI : z1;
    fold = 1'b0;
    zf = z2;
    if (z2 > ANG_HALF_PI) begin
      zf = ANG_PI - z2;
      fold = 1'b1;
    end else if (z2 < -ANG_HALF_PI) begin
      zf = -ANG_PI - z2;
      fold = 1'b1;
    end
    xs  = cx >>> cmd.iter;
    ys  = cyv >>> cmd.iter;
    atn = atan_q28(5'(cmd.iter));
    xo  = cneg ? -cx : cx;
    xr  = xo + CW'(32768);
    qv  = xr[33:16];
    qc  = (qv > 18'sd16384) ? 16'sd16384 : (qv < -18'sd16384) ? -16'sd16384 : qv[15:0];
    xr  = cyv + CW'(32768);
    qy  = xr[33:16];
    qs  = (qy > 18'sd16384) ? 16'sd16384 : (qy < -18'sd16384) ? -16'sd16384 : qy[15:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.cordic_init) begin
      cx   <= CORDIC_GAIN;
      cyv  <= '0;
      cz   <= zf;
      cneg <= fold;
    end else if (cmd.cordic_step) begin
      if (!cz[CW-1]) begin
        cx  <= cx - ys;
        cyv <= cyv + xs;
        cz  <= cz - atn;
      end else begin
        cx  <= cx + ys;
        cyv <= cyv - xs;
        cz  <= cz + atn;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sy <= '0; cy <= 16'sd16384; sp <= '0; cp <= 16'sd16384;
    end else if (cmd.cordic_store) begin
      if (cmd.cordic_sel) begin
        sp <= qs; cp <= qc;
      end else begin
        sy <= qs; cy <= qc;
      end
    end
  end

  // Right axis flips with the sign of cos pitch.
  logic signed [15:0] rx, rz;
  assign rx = cp[15] ? -cy : cy;
  assign rz = cp[15] ? sy : -sy;

  function automatic logic signed [32:0] pick(
    input src_t s, input logic signed [15:0] a_sy, input logic signed [15:0] a_cy,
    input logic signed [15:0] a_sp, input logic signed [15:0] a_cp,
    input logic signed [15:0] a_rx, input logic signed [15:0] a_rz,
    input logic signed [31:0] a_p0, input logic signed [31:0] a_p1,
    input logic signed [31:0] a_p2, input logic signed [31:0] a_p3,
    input logic signed [31:0] a_px, input logic signed [31:0] a_py,
    input logic signed [31:0] a_pz, input logic signed [31:0] a_dx,
    input logic signed [31:0] a_dz);
    logic signed [32:0] v;
    case (s)
      SRC_SY: v = ext16(a_sy);
      SRC_CY: v = ext16(a_cy);
      SRC_SP: v = ext16(a_sp);
      SRC_CP: v = ext16(a_cp);
      SRC_RX: v = ext16(a_rx);
      SRC_RZ: v = ext16(a_rz);
      SRC_P0: v = ext32(a_p0);
      SRC_P1: v = ext32(a_p1);
      SRC_P2: v = ext32(a_p2);
      SRC_P3: v = ext32(a_p3);
      SRC_PX: v = ext32(a_px);
      SRC_PY: v = ext32(a_py);
      SRC_PZ: v = ext32(a_pz);
      SRC_DX: v = ext32(a_dx);
      SRC_DZ: v = ext32(a_dz);
      default: v = '0;
    endcase
    return v;
  endfunction

  op_t                op_cur;
  logic signed [32:0] opa, opb;

  always_comb begin
    op_cur = op_rom(cmd.op_idx);
    opa = pick(op_cur.a, sy, cy, sp, cp, rx, rz, p0, p1, p2, p3,
               pos_x, pos_y, pos_z, dx_q, dz_q);
    opb = pick(op_cur.b, sy, cy, sp, cp, rx, rz, p0, p1, p2, p3,
               pos_x, pos_y, pos_z, dx_q, dz_q);
  end

  // Stage one: multiply.
  always_ff @(posedge clk) begin
    if (rst) begin
      op_q <= mk(OK_NOP, SRC_SY, SRC_SY, 1'b0, 1'b0, 1'b0, DST_NONE);
    end else begin
      op_q <= cmd.op_valid ? op_cur : mk(OK_NOP, SRC_SY, SRC_SY, 1'b0, 1'b0, 1'b0,
                                        DST_NONE);
    end
  end

  always_ff @(posedge clk) begin
    prod <= opa * opb;
  end

  // Stage two: accumulate, store a pair product, or round and write back.
  logic signed [63:0] term, base, accr;
  logic signed [35:0] rq;
  logic signed [37:0] psum;

  always_comb begin
    term = op_q.sh ? {prod[49:0], 14'b0} : prod[63:0];
    base = op_q.clr ? '0 : acc;
    accr = acc + 64'sd134217728;
    rq   = accr[63:28];
    case (op_q.dst)
      DST_PX:  psum = {{6{pos_x[31]}}, pos_x} + {{2{rq[35]}}, rq};
      DST_PY:  psum = {{6{pos_y[31]}}, pos_y} + {{6{dy_q[31]}}, dy_q}
                      + {{2{rq[35]}}, rq};
      DST_PZ:  psum = {{6{pos_z[31]}}, pos_z} + {{2{rq[35]}}, rq};
      default: psum = {{2{rq[35]}}, rq};
    endcase
  end

  always_ff @(posedge clk) begin
    if (op_q.kind == OK_MAC) begin
      acc <= op_q.neg ? base - term : base + term;
    end
    if (op_q.kind == OK_PROD) begin
      case (op_q.dst)
        DST_P0:  p0 <= prod[31:0];
        DST_P1:  p1 <= prod[31:0];
        DST_P2:  p2 <= prod[31:0];
        DST_P3:  p3 <= prod[31:0];
        default: ;
      endcase
    end
    if (op_q.kind == OK_WB) begin
      case (op_q.dst)
        DST_TX:  tx <= sat32(psum);
        DST_TY:  ty <= sat32(psum);
        DST_TZ:  tz <= sat32(psum);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0; pos_y <= '0; pos_z <= '0;
    end else if (cmd.load_in && mode) begin
      pos_x <= delta_x; pos_y <= delta_y; pos_z <= delta_z;
    end else if (op_q.kind == OK_WB) begin
      case (op_q.dst)
        DST_PX:  pos_x <= sat32(psum);
        DST_PY:  pos_y <= sat32(psum);
        DST_PZ:  pos_z <= sat32(psum);
        default: ;
      endcase
    end
  end

  assign rot_00  = cy;
  assign rot_01  = rnd14(p0);
  assign rot_02  = rnd14(p1);
  assign rot_10  = '0;
  assign rot_11  = cp;
  assign rot_12  = -sp;
  assign rot_20  = -sy;
  assign rot_21  = rnd14(p2);
  assign rot_22  = rnd14(p3);
  assign trans_x = tx;
  assign trans_y = ty;
  assign trans_z = tz;

endmodule

FILE: rtl/fps_camera_pose_and_view.sv
// Top level of the first-person camera pose and view-matrix block.
// Joins fpscam_ctrl and fpscam_datapath; uses fpscam_pkg.
//
// Input channel (in_valid/in_ready) takes one item: mode, new yaw and pitch
// (Q4.12 radians) and three Q16.16 values that either move the stored
// position along right, world up and forward (mode 0) or replace it
// (mode 1). Output channel (out_valid/out_ready) returns one item per input:
// the 3x3 view rotation in Q2.14 and the saturated Q16.16 translation row.
// One item is in flight at a time. After acceptance the shared CORDIC unit
// runs twice, once per angle (init, CORDIC_STEPS rotations, store), then
// the single multiplier works through its program (24 steps in mode 0, 16
// in mode 1, which skips the move) and a drain state follows. Once the
// result is taken the block returns to idle before it takes a new item.
// While the receiver stalls the result is held unchanged and no new item
// is taken. Reset clears position and angles to zero and returns to idle.
module fps_camera_pose_and_view (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic signed [15:0] yaw_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [31:0] delta_x,
  input  logic signed [31:0] delta_y,
  input  logic signed [31:0] delta_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] rot_00,
  output logic signed [15:0] rot_01,
  output logic signed [15:0] rot_02,
  output logic signed [15:0] rot_10,
  output logic signed [15:0] rot_11,
  output logic signed [15:0] rot_12,
  output logic signed [15:0] rot_20,
  output logic signed [15:0] rot_21,
  output logic signed [15:0] rot_22,
  output logic signed [31:0] trans_x,
  output logic signed [31:0] trans_y,
  output logic signed [31:0] trans_z
);
  import fpscam_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  fpscam_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  fpscam_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .mode        (mode),
    .yaw_angle   (yaw_angle),
    .pitch_angle (pitch_angle),
    .delta_x     (delta_x),
    .delta_y     (delta_y),
    .delta_z     (delta_z),
    .rot_00      (rot_00),
    .rot_01      (rot_01),
    .rot_02      (rot_02),
    .rot_10      (rot_10),
    .rot_11      (rot_11),
    .rot_12      (rot_12),
    .rot_20      (rot_20),
    .rot_21      (rot_21),
    .rot_22      (rot_22),
    .trans_x     (trans_x),
    .trans_y     (trans_y),
    .trans_z     (trans_z)
  );

endmodule

FILE: rtl/fpscam_checker.sv
// Port-level checker for the camera pose block, bound to the top level.
// Depends on fps_camera_pose_and_view_assert.svh.
module fpscam_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] rot_10,
  input logic signed [31:0] trans_x
);
`include "fps_camera_pose_and_view_assert.svh"

  // A held result keeps its value while the receiver stalls.
  `FPSCAM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(trans_x))
  // The middle row never has an x term.
  `FPSCAM_ASSERT_NOW(a_rot10_zero, out_valid, rot_10 == 16'sd0)
  // Only one item is in flight: no intake while a result waits.
  `FPSCAM_ASSERT_NOW(a_one_item, out_valid, !in_ready)
  // A result never follows its item in the next cycle.
  `FPSCAM_ASSERT_NEXT(a_latency, in_valid && in_ready, !out_valid)

endmodule

bind fps_camera_pose_and_view fpscam_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .rot_10    (rot_10),
  .trans_x   (trans_x)
);

FILE: tb/tb_top.sv
// Self-checking testbench of the first-person camera pose and view block.
// Drives fps_camera_pose_and_view with directed and random items and checks
// every result against a fixed-point camera predictor held in a scoreboard.
typedef struct {
  logic signed [15:0] rot [9];
  logic signed [31:0] tr [3];
} view_t;

class camera_scoreboard;
  longint pos_x, pos_y, pos_z;
  view_t views_due [$];
  int errors;
  int checked;

  function new();
    pos_x = 0; pos_y = 0; pos_z = 0;
    errors = 0; checked = 0;
  endfunction

  static function longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  static function longint round_at(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  static function longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  static function longint unit_clamp(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  static function longint atan_entry(int i);
    longint t [24] = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
      4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384,
      8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};
    return t[i];
  endfunction

  // Fixed-gain CORDIC in rotation mode; angle folded into [-pi/2, pi/2].
  static function void sin_cos(logic signed [15:0] ang, output longint s,
                               output longint c);
    longint z, x, y, nx;
    bit flip;
    z = longint'(ang) * 65536;
    x = 652032874; y = 0; flip = 0;
    if (z > 843314857) z -= 1686629713;
    if (z < -843314857) z += 1686629713;
    if (z > 421657428) begin
      z = 843314857 - z; flip = 1;
    end else if (z < -421657428) begin
      z = -843314857 - z; flip = 1;
    end
    for (int i = 0; i < fpscam_pkg::CORDIC_STEPS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i); y = y + floor_shift(x, i); z -= atan_entry(i);
      end else begin
        nx = x + floor_shift(y, i); y = y - floor_shift(x, i); z += atan_entry(i);
      end
      x = nx;
    end
    if (flip) x = -x;
    c = unit_clamp(round_at(x, 16));
    s = unit_clamp(round_at(y, 16));
  endfunction

  function void note_item(bit mode, logic signed [15:0] yaw, logic signed [15:0] pitch,
                          logic signed [31:0] dx, logic signed [31:0] dy,
                          logic signed [31:0] dz);
    longint sy, cy, sp, cp, rx, rz, acc;
    longint r [9];
    view_t v;
    sin_cos(yaw, sy, cy);
    sin_cos(pitch, sp, cp);
    if (mode) begin
      pos_x = dx; pos_y = dy; pos_z = dz;
    end else begin
      rx = cy; rz = -sy;
      // Looking past straight up or down flips the right axis.
      if (cp < 0) begin
        rx = -rx; rz = -rz;
      end
      acc = rx * longint'(dx) * 16384 + sy * cp * longint'(dz);
      pos_x = sat32(pos_x + round_at(acc, 28));
      acc = sp * longint'(dz) * 16384;
      pos_y = sat32(pos_y + longint'(dy) + round_at(acc, 28));
      acc = rz * longint'(dx) * 16384 + cy * cp * longint'(dz);
      pos_z = sat32(pos_z + round_at(acc, 28));
    end
    r[0] = cy; r[1] = round_at(sy * sp, 14); r[2] = round_at(sy * cp, 14);
    r[3] = 0;  r[4] = cp;                    r[5] = -sp;
    r[6] = -sy; r[7] = round_at(cy * sp, 14); r[8] = round_at(cy * cp, 14);
    foreach (r[k]) v.rot[k] = r[k][15:0];
    acc = pos_x * cy * 16384 - pos_z * sy * 16384;
    v.tr[0] = 32'(sat32(round_at(-acc, 28)));
    acc = pos_x * (sy * sp) + pos_y * cp * 16384 + pos_z * (cy * sp);
    v.tr[1] = 32'(sat32(round_at(-acc, 28)));
    acc = pos_x * (sy * cp) - pos_y * sp * 16384 + pos_z * (cy * cp);
    v.tr[2] = 32'(sat32(round_at(-acc, 28)));
    views_due.push_back(v);
  endfunction

  function void check_view(view_t got);
    view_t e;
    string rn [9] = '{"rot_00", "rot_01", "rot_02", "rot_10", "rot_11", "rot_12",
                      "rot_20", "rot_21", "rot_22"};
    string tn [3] = '{"trans_x", "trans_y", "trans_z"};
    if (views_due.size() == 0) begin
      $error("unexpected result item");
      errors++;
      return;
    end
    e = views_due.pop_front();
    checked++;
    foreach (e.rot[k])
      if (e.rot[k] !== got.rot[k]) begin
        $error("%s expected %0d got %0d", rn[k], e.rot[k], got.rot[k]);
        errors++;
      end
    foreach (e.tr[k])
      if (e.tr[k] !== got.tr[k]) begin
        $error("%s expected %0d got %0d", tn[k], e.tr[k], got.tr[k]);
        errors++;
      end
  endfunction
endclass

module tb_top;
  import fpscam_pkg::*;

  localparam int RANDOM_ITEMS = 880;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic mode = 0;
  logic signed [15:0] yaw_angle = 0, pitch_angle = 0;
  logic signed [31:0] delta_x = 0, delta_y = 0, delta_z = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [15:0] rot_00, rot_01, rot_02, rot_10, rot_11, rot_12;
  logic signed [15:0] rot_20, rot_21, rot_22;
  logic signed [31:0] trans_x, trans_y, trans_z;

  camera_scoreboard views;
  bit stim_done = 0;
  bit hold_off = 0;
  int idle_cycles = 0;
  int sent = 0;

  fps_camera_pose_and_view i_dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 120) : $urandom_range(0, 3);
  endfunction

  function automatic logic signed [15:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return -16'sh8000;
      2: return $urandom_range(0, 1) ? 16'sd6434 : -16'sd6434;
      3: return $urandom_range(0, 1) ? 16'sd12868 : -16'sd12868;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic signed [31:0] pick_delta();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      default: return $urandom();
    endcase
  endfunction

  // Valid stays high into the next item when that item follows at once.
  task automatic send_item(bit m, logic signed [15:0] y, logic signed [15:0] p,
                           logic signed [31:0] dx, logic signed [31:0] dy,
                           logic signed [31:0] dz, bit allow_gap);
    int g;
    g = allow_gap ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1; mode <= m; yaw_angle <= y; pitch_angle <= p;
    delta_x <= dx; delta_y <= dy; delta_z <= dz;
    do @(posedge clk); while (!in_ready);
    views.note_item(m, y, p, dx, dy, dz);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (views.views_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    views = new();
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: angle extremes, quarter turns, both modes, saturation.
    send_item(0, 0, 0, 0, 0, 0, 0);
    send_item(1, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0);
    send_item(0, 16'sh7fff, -16'sh8000, 0, 0, 0, 0);
    send_item(0, 16'sd6434, 16'sd6434, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0);
    send_item(0, -16'sd6434, -16'sd6434, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
    send_item(0, 16'sd12868, 16'sd12868, 32'sh10000, 32'sh10000, 32'sh10000, 0);
    send_item(0, -16'sd12868, -16'sd12868, 32'sh10000, 32'sh10000, 32'sh10000, 0);
    send_item(1, 16'sd3217, 16'sd9651, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0);
    send_item(0, 16'sd3217, 16'sd9651, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0);
    send_item(0, -16'sd25736, 16'sd25736, 32'sh12345678, -32'sh1234567, 32'sh0badf00d, 0);
    send_item(1, -16'sh8000, 16'sh7fff, 0, 0, 0, 0);
    send_item(0, 16'sd6433, 16'sd6435, -32'sh10000, 32'sh10000, -32'sh10000, 0);
    // Random: mostly moves, occasional loads, mixed small, full-range and extreme values.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        wait_drained();
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
      send_item($urandom_range(0, 7) == 0, pick_angle(), pick_angle(),
                pick_delta(), pick_delta(), pick_delta(), 1);
    end
    in_valid <= 0;
    stim_done = 1;
  end

  // Receiver: random stalls, and one long hold-off while the sender still has items to send.
  initial begin
    int g;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (sent == 200 && !hold_off) begin
        hold_off = 1;
        out_ready <= 0;
        repeat (400) @(posedge clk);
      end
      g = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
      if (g > 0) begin
        out_ready <= 0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1;
    end
  end

  always @(posedge clk) begin
    view_t got;
    if (!rst && out_valid && out_ready) begin
      got.rot = '{rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22};
      got.tr = '{trans_x, trans_y, trans_z};
      views.check_view(got);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (stim_done);
    while (views.views_due.size() != 0 && idle_cycles < IDLE_LIMIT) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("Covered %0d items in both modes, %0d results checked.", sent, views.checked);
    if (views.errors == 0 && views.views_due.size() == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("Watchdog: no handshake for %0d cycles.", IDLE_LIMIT);
    $display("tb_top failed");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/fpscam_pkg.sv
rtl/fpscam_ctrl.sv
rtl/fpscam_datapath.sv
rtl/fps_camera_pose_and_view.sv
rtl/fpscam_checker.sv
tb/tb_top.sv
